// ===== rtl/jvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick velocity mapper package
// Shared widths, register indexes and state codes of the velocity mapper.
// ----------------------------------------------------------------------------
package jvm_pkg;

    localparam int SMP_W  = 12;
    localparam int SPD_W  = 16;
    localparam int VMAX_W = 15;
    localparam int TIME_W = 32;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 4;

    localparam logic [SMP_W-1:0]  RST_LOW_END  = 12'd0;
    localparam logic [SMP_W-1:0]  RST_REST     = 12'd2048;
    localparam logic [SMP_W-1:0]  RST_HIGH_END = 12'd4095;
    localparam logic [SMP_W-1:0]  RST_DEAD     = 12'd80;
    localparam logic [VMAX_W-1:0] RST_VMAX     = 15'd1000;

    typedef enum logic [2:0] {
        REG_X_LOW_END  = 3'd0,
        REG_X_REST     = 3'd1,
        REG_X_HIGH_END = 3'd2,
        REG_Y_LOW_END  = 3'd3,
        REG_Y_REST     = 3'd4,
        REG_Y_HIGH_END = 3'd5,
        REG_DEAD_BAND  = 3'd6,
        REG_SPEED_LIM  = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

endpackage

// ===== rtl/jvm_if.sv =====
// ----------------------------------------------------------------------------
// Joystick velocity mapper channels
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface jvm_smp_if import jvm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SMP_W-1:0]  x_sample;
    logic [SMP_W-1:0]  y_sample;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, x_sample, y_sample, button_level, now_ms, input ready);
    modport sink   (input valid, x_sample, y_sample, button_level, now_ms, output ready);
endinterface

interface jvm_res_if import jvm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SMP_W-1:0]        x_position;
    logic [SMP_W-1:0]        y_position;
    logic [SMP_W-1:0]        z_position;
    logic signed [SPD_W-1:0] x_speed;
    logic signed [SPD_W-1:0] y_speed;
    logic signed [SPD_W-1:0] z_speed;
    logic                    z_mode_on;

    modport source (output valid, x_position, y_position, z_position, x_speed, y_speed,
                    z_speed, z_mode_on, input ready);
    modport sink   (input valid, x_position, y_position, z_position, x_speed, y_speed,
                    z_speed, z_mode_on, output ready);
endinterface

// ===== rtl/joystick_velocity_mapper.sv =====
// ----------------------------------------------------------------------------
// Joystick velocity mapper
// Debounces the button into a Z mode toggle, routes the axis readings and
// maps each routed axis to a clamped velocity with a dead zone.
//
// Channels: samples enter on i_smp and results leave on o_res, both with a
// valid/ready handshake; one result item per sample item. Calibration and
// limits are written through the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce.
// The three velocities share one bit-serial divider that walks the speed
// limit one bit per cycle, 15 steps per axis. An axis in the dead zone or in
// saturation skips the divider. The result valid rises as the result is
// moved into the output register, and the next sample is accepted in the
// cycle after that move, so no new sample is taken while one is in work.
// Reset loads the calibration defaults, releases the debounced button and
// turns Z mode off. When the receiver stalls, the finished result waits in
// the output register while the next sample is taken and processed; that
// sample then holds until the output register frees up.
// ----------------------------------------------------------------------------
module joystick_velocity_mapper import jvm_pkg::*; #(
    parameter int unsigned DEBOUNCE_MS = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jvm_smp_if.sink           i_smp,
    jvm_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [TIME_W-1:0] DEB_TICKS = TIME_W'(DEBOUNCE_MS);

    logic [SMP_W-1:0]  r_x_low_end, r_x_rest, r_x_high_end;
    logic [SMP_W-1:0]  r_y_low_end, r_y_rest, r_y_high_end;
    logic [SMP_W-1:0]  r_dead_band;
    logic [VMAX_W-1:0] r_speed_limit;

    logic              r_prev_level, r_stable_level, r_z_mode;
    logic [TIME_W-1:0] r_change_stamp;

    t_state            r_state;
    t_axis             r_axis;
    logic [SMP_W-1:0]  r_xp, r_yp, r_zp;
    logic signed [SPD_W-1:0] r_spd_x, r_spd_y;
    logic [SMP_W-1:0]  r_mag, r_span;
    logic              r_neg;
    logic [SMP_W:0]    r_rem;
    logic [VMAX_W-1:0] r_quo, r_vsh;
    logic [CNT_W-1:0]  r_cnt;

    logic                    r_out_valid;
    logic [SMP_W-1:0]        r_out_xp, r_out_yp, r_out_zp;
    logic signed [SPD_W-1:0] r_out_sx, r_out_sy, r_out_sz;
    logic                    r_out_zm;

    logic              w_cfg_wr, w_accept, w_settle, w_z_next, w_load_out;
    t_reg_idx          w_idx;
    logic [SMP_W-1:0]  w_val, w_c, w_l, w_h, w_mag;
    logic [SMP_W:0]    w_delta, w_span_raw;
    logic              w_pos, w_inv, w_neg, w_zero, w_sat;
    logic [SMP_W+1:0]  w_t, w_t1, w_t2;
    logic [1:0]        w_dig;
    logic [SMP_W:0]    n_rem;
    logic [VMAX_W-1:0] n_quo, w_fin_mag;
    logic              w_fin_neg, w_fin;
    logic signed [SPD_W-1:0] w_spd;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_X_LOW_END:  prdata = DATA_W'(r_x_low_end);
            REG_X_REST:     prdata = DATA_W'(r_x_rest);
            REG_X_HIGH_END: prdata = DATA_W'(r_x_high_end);
            REG_Y_LOW_END:  prdata = DATA_W'(r_y_low_end);
            REG_Y_REST:     prdata = DATA_W'(r_y_rest);
            REG_Y_HIGH_END: prdata = DATA_W'(r_y_high_end);
            REG_DEAD_BAND:  prdata = DATA_W'(r_dead_band);
            REG_SPEED_LIM:  prdata = DATA_W'(r_speed_limit);
            default:        prdata = '0;
        endcase
    end

    assign i_smp.ready = (r_state == S_IDLE);
    assign w_accept    = i_smp.valid && i_smp.ready;

    // A level change restarts the timer, so settling needs an unchanged level.
    assign w_settle = (i_smp.button_level == r_prev_level)
                   && ((i_smp.now_ms - r_change_stamp) > DEB_TICKS)
                   && (i_smp.button_level != r_stable_level);
    assign w_z_next = r_z_mode ^ (w_settle && !i_smp.button_level);

    always_comb begin
        w_val = r_xp;
        w_c   = r_x_rest;
        w_l   = r_x_low_end;
        w_h   = r_x_high_end;
        w_inv = 1'b0;
        case (r_axis)
            AX_X: begin
                w_val = r_xp;
            end
            AX_Y: begin
                w_val = r_yp;
                w_c   = r_y_rest;
                w_l   = r_y_low_end;
                w_h   = r_y_high_end;
            end
            AX_Z: begin
                w_val = r_zp;
                w_c   = r_y_rest;
                w_l   = r_y_low_end;
                w_h   = r_y_high_end;
                w_inv = 1'b1;
            end
            default: begin
                w_val = r_xp;
            end
        endcase
    end

    assign w_delta    = {1'b0, w_val} - {1'b0, w_c};
    assign w_pos      = !w_delta[SMP_W] && (w_delta != '0);
    assign w_mag      = w_delta[SMP_W] ? SMP_W'(-w_delta) : w_delta[SMP_W-1:0];
    assign w_span_raw = w_pos ? ({1'b0, w_h} - {1'b0, w_c}) : ({1'b0, w_c} - {1'b0, w_l});
    assign w_neg      = (w_pos == w_inv);
    assign w_zero     = (w_mag < r_dead_band) || (w_mag == '0);
    assign w_sat      = w_span_raw[SMP_W] || (w_span_raw == '0)
                     || ({1'b0, w_mag} > w_span_raw);

    // One quotient digit per speed-limit bit; the digit is 0, 1 or 2.
    assign w_t  = {r_rem, 1'b0} + (r_vsh[VMAX_W-1] ? (SMP_W+2)'(r_mag) : '0);
    assign w_t1 = w_t - (SMP_W+2)'(r_span);
    assign w_t2 = w_t - (SMP_W+2)'({r_span, 1'b0});
    always_comb begin
        if (w_t >= (SMP_W+2)'({r_span, 1'b0})) begin
            n_rem = w_t2[SMP_W:0];
            w_dig = 2'd2;
        end else if (w_t >= (SMP_W+2)'(r_span)) begin
            n_rem = w_t1[SMP_W:0];
            w_dig = 2'd1;
        end else begin
            n_rem = w_t[SMP_W:0];
            w_dig = 2'd0;
        end
    end
    assign n_quo = {r_quo[VMAX_W-2:0], 1'b0} + VMAX_W'(w_dig);

    assign w_fin     = (r_state == S_DIV) ? (r_cnt == CNT_W'(1)) : (w_zero || w_sat);
    assign w_fin_neg = (r_state == S_DIV) ? r_neg : w_neg;
    always_comb begin
        if (r_state == S_DIV) begin
            w_fin_mag = n_quo;
        end else if (w_zero) begin
            w_fin_mag = '0;
        end else begin
            w_fin_mag = r_speed_limit;
        end
    end
    assign w_spd = w_fin_neg ? -SPD_W'({1'b0, w_fin_mag}) : SPD_W'({1'b0, w_fin_mag});

    assign w_load_out = (r_state == S_HOLD) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low_end    <= RST_LOW_END;
            r_x_rest       <= RST_REST;
            r_x_high_end   <= RST_HIGH_END;
            r_y_low_end    <= RST_LOW_END;
            r_y_rest       <= RST_REST;
            r_y_high_end   <= RST_HIGH_END;
            r_dead_band    <= RST_DEAD;
            r_speed_limit  <= RST_VMAX;
            r_prev_level   <= 1'b1;
            r_stable_level <= 1'b1;
            r_change_stamp <= '0;
            r_z_mode       <= 1'b0;
            r_state        <= S_IDLE;
            r_axis         <= AX_X;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_idx)
                    REG_X_LOW_END:  r_x_low_end   <= pwdata[SMP_W-1:0];
                    REG_X_REST:     r_x_rest      <= pwdata[SMP_W-1:0];
                    REG_X_HIGH_END: r_x_high_end  <= pwdata[SMP_W-1:0];
                    REG_Y_LOW_END:  r_y_low_end   <= pwdata[SMP_W-1:0];
                    REG_Y_REST:     r_y_rest      <= pwdata[SMP_W-1:0];
                    REG_Y_HIGH_END: r_y_high_end  <= pwdata[SMP_W-1:0];
                    REG_DEAD_BAND:  r_dead_band   <= pwdata[SMP_W-1:0];
                    REG_SPEED_LIM:  r_speed_limit <= pwdata[VMAX_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_smp.button_level != r_prev_level) begin
                            r_change_stamp <= i_smp.now_ms;
                        end
                        if (w_settle) begin
                            r_stable_level <= i_smp.button_level;
                        end
                        r_prev_level <= i_smp.button_level;
                        r_z_mode     <= w_z_next;
                        r_axis       <= AX_X;
                        r_state      <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    if (w_fin) begin
                        if (r_axis == AX_Z) begin
                            r_state <= S_HOLD;
                        end else begin
                            r_axis <= t_axis'(r_axis + 2'd1);
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_fin) begin
                        if (r_axis == AX_Z) begin
                            r_state <= S_HOLD;
                        end else begin
                            r_axis  <= t_axis'(r_axis + 2'd1);
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_HOLD: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_z_next) begin
                r_xp <= r_x_rest;
                r_yp <= r_y_rest;
                r_zp <= i_smp.y_sample;
            end else begin
                r_xp <= i_smp.x_sample;
                r_yp <= i_smp.y_sample;
                r_zp <= r_y_rest;
            end
        end
        if (r_state == S_SETUP) begin
            r_mag  <= w_mag;
            r_span <= w_span_raw[SMP_W-1:0];
            r_neg  <= w_neg;
            r_rem  <= '0;
            r_quo  <= '0;
            r_vsh  <= r_speed_limit;
            r_cnt  <= CNT_W'(VMAX_W);
        end
        if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_vsh <= {r_vsh[VMAX_W-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if ((r_state == S_SETUP || r_state == S_DIV) && w_fin) begin
            case (r_axis)
                AX_X:    r_spd_x  <= w_spd;
                AX_Y:    r_spd_y  <= w_spd;
                AX_Z:    r_out_sz <= w_spd;
                default: r_spd_x  <= w_spd;
            endcase
        end
        if (w_load_out) begin
            r_out_xp <= r_xp;
            r_out_yp <= r_yp;
            r_out_zp <= r_zp;
            r_out_sx <= r_spd_x;
            r_out_sy <= r_spd_y;
            r_out_zm <= r_z_mode;
        end
    end

    logic signed [SPD_W-1:0] r_z_held;
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_z_held <= r_out_sz;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.x_position = r_out_xp;
    assign o_res.y_position = r_out_yp;
    assign o_res.z_position = r_out_zp;
    assign o_res.x_speed    = r_out_sx;
    assign o_res.y_speed    = r_out_sy;
    assign o_res.z_speed    = r_z_held;
    assign o_res.z_mode_on  = r_out_zm;

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt != '0)
        else $error("divider running with an exhausted step count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> {1'b0, r_rem} < {2'b0, r_span})
        else $error("divider remainder not below the span");

    a_load_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_HOLD))
        else $error("result presented without a finished item");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SETUP && r_axis == AX_X)
        else $error("accepted item did not start at the first axis");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Joystick velocity mapper testbench
// Drives samples through the valid/ready channels with random gaps and
// stalls and predicts every result from a model of the debounce, routing and
// velocity mapping. It also walks the calibration through several settings
// over APB, with extreme, unordered and degenerate spans among them.
// ----------------------------------------------------------------------------
module tb import jvm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_MS   = 50;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [SMP_W-1:0]  x;
        logic [SMP_W-1:0]  y;
        logic              lvl;
        logic [TIME_W-1:0] now;
    } t_sample;

    typedef struct packed {
        logic [SMP_W-1:0]        x_pos;
        logic [SMP_W-1:0]        y_pos;
        logic [SMP_W-1:0]        z_pos;
        logic signed [SPD_W-1:0] x_spd;
        logic signed [SPD_W-1:0] y_spd;
        logic signed [SPD_W-1:0] z_spd;
        logic                    zmode;
    } t_motion;

    class motion_tracker;
        logic [15:0]       cal [8];
        logic              prev_lvl;
        logic              settled_lvl;
        logic              zmode;
        logic [TIME_W-1:0] change_ms;
        t_motion           due[$];
        int                mismatches;
        int                noted;
        int                checked;
        int                toggles;

        function new();
            cal[REG_X_LOW_END]  = 16'(RST_LOW_END);
            cal[REG_X_REST]     = 16'(RST_REST);
            cal[REG_X_HIGH_END] = 16'(RST_HIGH_END);
            cal[REG_Y_LOW_END]  = 16'(RST_LOW_END);
            cal[REG_Y_REST]     = 16'(RST_REST);
            cal[REG_Y_HIGH_END] = 16'(RST_HIGH_END);
            cal[REG_DEAD_BAND]  = 16'(RST_DEAD);
            cal[REG_SPEED_LIM]  = 16'(RST_VMAX);
            prev_lvl    = 1'b1;
            settled_lvl = 1'b1;
            zmode       = 1'b0;
            change_ms   = '0;
            mismatches  = 0;
            noted       = 0;
            checked     = 0;
            toggles     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            cal[idx] = (idx == REG_SPEED_LIM) ? 16'(value[14:0]) : 16'(value[11:0]);
        endfunction

        function int pending();
            return due.size();
        endfunction

        function logic signed [SPD_W-1:0] axis_velocity(logic [SMP_W-1:0] value,
                logic [SMP_W-1:0] centre, logic [SMP_W-1:0] low_end,
                logic [SMP_W-1:0] high_end, bit invert);
            longint vmax;
            longint delta;
            longint mag;
            longint span;
            longint v;
            vmax  = longint'(cal[REG_SPEED_LIM]);
            delta = longint'(value) - longint'(centre);
            mag   = (delta < 0) ? -delta : delta;
            if (mag < longint'(cal[REG_DEAD_BAND])) begin
                return '0;
            end
            span = (delta > 0) ? longint'(high_end) - longint'(centre)
                               : longint'(centre) - longint'(low_end);
            if (delta == 0) begin
                v = 0;
            end else if (span <= 0) begin
                v = (delta > 0) ? vmax : -vmax;
            end else begin
                v = (mag * vmax) / span;
                if (delta < 0) begin
                    v = -v;
                end
            end
            if (invert) begin
                v = -v;
            end
            if (v > vmax) begin
                v = vmax;
            end
            if (v < -vmax) begin
                v = -vmax;
            end
            return SPD_W'(v);
        endfunction

        function void take_sample(t_sample s);
            t_motion want;
            if (s.lvl != prev_lvl) begin
                change_ms = s.now;
            end
            if (TIME_W'(s.now - change_ms) > TIME_W'(SETTLE_MS) && s.lvl != settled_lvl) begin
                settled_lvl = s.lvl;
                if (!s.lvl) begin
                    zmode = !zmode;
                    toggles++;
                end
            end
            prev_lvl = s.lvl;
            if (zmode) begin
                want.x_pos = cal[REG_X_REST][SMP_W-1:0];
                want.y_pos = cal[REG_Y_REST][SMP_W-1:0];
                want.z_pos = s.y;
            end else begin
                want.x_pos = s.x;
                want.y_pos = s.y;
                want.z_pos = cal[REG_Y_REST][SMP_W-1:0];
            end
            want.x_spd = axis_velocity(want.x_pos, cal[REG_X_REST][SMP_W-1:0],
                                       cal[REG_X_LOW_END][SMP_W-1:0],
                                       cal[REG_X_HIGH_END][SMP_W-1:0], 1'b0);
            want.y_spd = axis_velocity(want.y_pos, cal[REG_Y_REST][SMP_W-1:0],
                                       cal[REG_Y_LOW_END][SMP_W-1:0],
                                       cal[REG_Y_HIGH_END][SMP_W-1:0], 1'b0);
            want.z_spd = axis_velocity(want.z_pos, cal[REG_Y_REST][SMP_W-1:0],
                                       cal[REG_Y_LOW_END][SMP_W-1:0],
                                       cal[REG_Y_HIGH_END][SMP_W-1:0], 1'b1);
            want.zmode = zmode;
            due.push_back(want);
            noted++;
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_motion(t_motion got);
            t_motion want;
            if (due.size() == 0) begin
                mismatches++;
                $error("result item arrived with no sample outstanding");
                return;
            end
            want = due.pop_front();
            checked++;
            compare_field("x_position", want.x_pos, got.x_pos);
            compare_field("y_position", want.y_pos, got.y_pos);
            compare_field("z_position", want.z_pos, got.z_pos);
            compare_field("x_speed", want.x_spd, got.x_spd);
            compare_field("y_speed", want.y_spd, got.y_spd);
            compare_field("z_speed", want.z_spd, got.z_spd);
            compare_field("z_mode_on", want.zmode, got.zmode);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    jvm_smp_if smp ();
    jvm_res_if res ();

    motion_tracker tracker = new();

    bit              tx_idle = 1'b1;
    bit              rx_idle = 1'b1;
    bit              hold_req = 1'b0;
    logic [31:0]     t_ms = 32'd0;
    logic            lvl_now = 1'b1;
    int              lvl_left = 0;
    int              n_settings = 1;

    joystick_velocity_mapper #(
        .DEBOUNCE_MS (SETTLE_MS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && smp.valid && smp.ready) begin
            tracker.take_sample('{smp.x_sample, smp.y_sample, smp.button_level, smp.now_ms});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            tracker.check_motion('{res.x_position, res.y_position, res.z_position,
                                   res.x_speed, res.y_speed, res.z_speed, res.z_mode_on});
        end
    end

    initial begin : result_sink
        int stall;
        res.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                res.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res.ready = 1'b1;
            do @(posedge i_clk); while (res.valid !== 1'b1);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $error("no handshake for %0d cycles", QUIET_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_sample(logic [SMP_W-1:0] xs, logic [SMP_W-1:0] ys, logic lvl,
                               logic [TIME_W-1:0] stamp);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            smp.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp.valid        = 1'b1;
        smp.x_sample     = xs;
        smp.y_sample     = ys;
        smp.button_level = lvl;
        smp.now_ms       = stamp;
        do @(posedge i_clk); while (!smp.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        smp.valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        mask    = (idx == REG_SPEED_LIM) ? 32'h7FFF : 32'hFFF;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = (value & mask) | ($urandom & ~mask);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        tracker.set_reg(idx, value);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== 32'(tracker.cal[idx])) begin
            tracker.mismatches++;
            $error("%s readback: expected %0d, got %0d", idx.name(), tracker.cal[idx], readback);
        end
    endtask

    task automatic set_calibration(int xl, int xr, int xh, int yl, int yr, int yh,
                                   int band, int vmax);
        drain();
        write_reg(REG_X_LOW_END, xl);
        write_reg(REG_X_REST, xr);
        write_reg(REG_X_HIGH_END, xh);
        write_reg(REG_Y_LOW_END, yl);
        write_reg(REG_Y_REST, yr);
        write_reg(REG_Y_HIGH_END, yh);
        write_reg(REG_DEAD_BAND, band);
        write_reg(REG_SPEED_LIM, vmax);
        n_settings++;
    endtask

    function automatic logic [SMP_W-1:0] pick_reading(logic [15:0] centre);
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return SMP_W'(centre) + SMP_W'($urandom_range(0, 400)) - SMP_W'(200);
            end
            default: begin
                return SMP_W'($urandom_range(0, 4095));
            end
        endcase
    endfunction

    task automatic random_calibration();
        int cv [8];
        bit ordered;
        ordered = ($urandom_range(0, 2) != 0);
        for (int a = 0; a < 2; a++) begin
            if (ordered) begin
                cv[3*a]     = $urandom_range(0, 1500);
                cv[3*a + 1] = $urandom_range(1500, 2600);
                cv[3*a + 2] = $urandom_range(2600, 4095);
            end else begin
                cv[3*a]     = $urandom_range(0, 4095);
                cv[3*a + 1] = $urandom_range(0, 4095);
                cv[3*a + 2] = $urandom_range(0, 4095);
            end
        end
        cv[6] = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
        cv[7] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 2000);
        set_calibration(cv[0], cv[1], cv[2], cv[3], cv[4], cv[5], cv[6], cv[7]);
    endtask

    task automatic run_random(int count);
        logic lvl;
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++) begin
            if (lvl_left == 0) begin
                lvl_now  = !lvl_now;
                lvl_left = $urandom_range(2, 8);
            end
            lvl_left--;
            lvl = ($urandom_range(0, 9) == 0) ? !lvl_now : lvl_now;
            if ($urandom_range(0, 39) == 0) begin
                t_ms = $urandom;
            end else begin
                t_ms = t_ms + $urandom_range(0, 30);
            end
            send_sample(pick_reading(tracker.cal[REG_X_REST]),
                        pick_reading(tracker.cal[REG_Y_REST]), lvl, t_ms);
            if (i == count / 2) begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        smp.valid        = 1'b0;
        smp.x_sample     = '0;
        smp.y_sample     = '0;
        smp.button_level = 1'b1;
        smp.now_ms       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Centre, full deflection and both edges of the dead zone.
        send_sample(12'd2048, 12'd2048, 1'b1, 32'd1000);
        send_sample(12'd0, 12'd4095, 1'b1, 32'd1001);
        send_sample(12'd4095, 12'd0, 1'b1, 32'd1002);
        send_sample(12'd2128, 12'd1969, 1'b1, 32'd1003);
        send_sample(12'd1968, 12'd2127, 1'b1, 32'd1004);
        // A press held exactly the debounce time does not settle; one more ms does.
        send_sample(12'd1000, 12'd3000, 1'b0, 32'd1010);
        send_sample(12'd3000, 12'd1000, 1'b0, 32'd1060);
        send_sample(12'd4095, 12'd4095, 1'b0, 32'd1061);
        send_sample(12'd0, 12'd0, 1'b0, 32'd1070);
        send_sample(12'd4095, 12'd2500, 1'b1, 32'd1080);
        send_sample(12'd100, 12'd3900, 1'b1, 32'd1200);
        // Bouncing contact restarts the timer before the press settles.
        send_sample(12'd2048, 12'd100, 1'b0, 32'd1210);
        send_sample(12'd2048, 12'd4000, 1'b1, 32'd1220);
        send_sample(12'd2048, 12'd0, 1'b0, 32'd1230);
        send_sample(12'd500, 12'd3500, 1'b0, 32'd1300);
        send_sample(12'd3500, 12'd500, 1'b1, 32'd1310);
        send_sample(12'd2047, 12'd2049, 1'b1, 32'd1400);
        // The timestamp wraps while the button is held.
        send_sample(12'd1, 12'd4094, 1'b0, 32'hFFFF_FFF0);
        send_sample(12'd4094, 12'd1, 1'b0, 32'h0000_0030);
        send_sample(12'd2048, 12'd4095, 1'b1, 32'hFFFF_FFFF);
        send_sample(12'd2048, 12'd0, 1'b1, 32'h0000_0020);
        send_sample(12'd2600, 12'd1500, 1'b1, 32'h0000_0060);
        t_ms = 32'h0000_0100;
        run_random(60);

        set_calibration(0, 2048, 4095, 0, 2048, 4095, 0, 32767);
        run_random(60);
        set_calibration(0, 2048, 4095, 0, 2048, 4095, 4095, 0);
        run_random(40);
        set_calibration(2048, 2048, 2048, 0, 0, 4095, 10, 1000);
        run_random(60);
        set_calibration(4095, 0, 0, 3000, 1000, 500, 0, 32767);
        run_random(60);
        set_calibration(4095, 4095, 4095, 4095, 4095, 4095, 4095, 32767);
        run_random(30);
        set_calibration(0, 0, 0, 0, 0, 0, 0, 1);
        run_random(30);

        // The receiver stops for a long stretch while samples keep coming.
        set_calibration(0, 2048, 4095, 0, 2048, 4095, 80, 1000);
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (25) begin
            t_ms = t_ms + $urandom_range(0, 30);
            send_sample(pick_reading(tracker.cal[REG_X_REST]),
                        pick_reading(tracker.cal[REG_Y_REST]), lvl_now, t_ms);
        end
        drain();

        repeat (6) begin
            random_calibration();
            run_random(50);
        end

        drain();
        repeat (60) @(posedge i_clk);
        $display("Covered %0d samples and %0d results under %0d calibration settings,",
                 tracker.noted, tracker.checked, n_settings);
        $display("with %0d Z mode toggles and random stalls on both channels.",
                 tracker.toggles);
        if (tracker.mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
